FILE: src/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define GAS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

// Check a property on every rising clock edge, reset included.
`define GAS_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("%m: property failed");

`endif

FILE: src/gas_pkg.sv
package gas_pkg;

    localparam int TIMER_BITS = 20;
    localparam int NUM_TIMERS = 6;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 3;

    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    // timer slots
    localparam int T_OPEN   = 0;
    localparam int T_CLOSE  = 1;
    localparam int T_PASS   = 2;
    localparam int T_GIVEUP = 3;
    localparam int T_OBST   = 4;
    localparam int T_DENIED = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_TO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GIVEUP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OBST     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DENIED   = 3'd6;

    localparam logic [19:0] RST_PASS_TO  = 20'd10000;
    localparam logic [13:0] RST_OPEN_TR  = 14'd1000;
    localparam logic [13:0] RST_CLOSE_TR = 14'd1000;
    localparam logic [15:0] RST_GIVEUP   = 16'd5000;
    localparam logic [15:0] RST_OBST     = 16'd5000;
    localparam logic [9:0]  RST_SETTLE   = 10'd500;
    localparam logic [13:0] RST_DENIED   = 14'd2500;

    // request kinds
    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_GRANTED = 3'd1;
    localparam logic [2:0] REQ_DENIED  = 3'd2;
    localparam logic [2:0] REQ_OPEN    = 3'd3;
    localparam logic [2:0] REQ_CLOSE   = 3'd4;
    localparam logic [2:0] REQ_PASSAGE = 3'd5;
    localparam logic [2:0] REQ_CLEARED = 3'd6;
    localparam logic [2:0] REQ_UNKNOWN = 3'd7;

    // gate states
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_OPENING   = 3'd1;
    localparam logic [2:0] ST_OPEN_WAIT = 3'd2;
    localparam logic [2:0] ST_WARN      = 3'd3;
    localparam logic [2:0] ST_CLOSING   = 3'd4;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_CLOSED  = 3'd1;
    localparam logic [2:0] EV_OPENING = 3'd2;
    localparam logic [2:0] EV_OPEN    = 3'd3;
    localparam logic [2:0] EV_WARN    = 3'd4;
    localparam logic [2:0] EV_CLOSING = 3'd5;

    localparam logic [1:0] ACK_NONE = 2'd0;
    localparam logic [1:0] ACK_OK   = 2'd1;
    localparam logic [1:0] ACK_BUSY = 2'd2;

    localparam logic [1:0] SERVO_NONE = 2'd0;
    localparam logic [1:0] SERVO_UP   = 2'd1;
    localparam logic [1:0] SERVO_DOWN = 2'd2;

    localparam logic [2:0] BZ_NONE       = 3'd0;
    localparam logic [2:0] BZ_OK         = 3'd1;
    localparam logic [2:0] BZ_ERROR      = 3'd2;
    localparam logic [2:0] BZ_WARN_START = 3'd3;
    localparam logic [2:0] BZ_WARN_STOP  = 3'd4;

    localparam logic [2:0] DISP_NONE    = 3'd0;
    localparam logic [2:0] DISP_IDLE    = 3'd1;
    localparam logic [2:0] DISP_OPENING = 3'd2;
    localparam logic [2:0] DISP_CLOSING = 3'd3;
    localparam logic [2:0] DISP_WARN    = 3'd4;
    localparam logic [2:0] DISP_DENIED  = 3'd5;
    localparam logic [2:0] DISP_NAME    = 3'd6;

    localparam logic [1:0] ACC_NONE    = 2'd0;
    localparam logic [1:0] ACC_GRANTED = 2'd1;
    localparam logic [1:0] ACC_DENIED  = 2'd2;

    localparam int OUT_W   = 49;
    localparam int OUT_PAD = 56 - OUT_W;

    typedef logic [TIMER_BITS-1:0] t_tcnt;

    // Load value of a timer: the register saturated to the counter width.
    function automatic t_tcnt tmr_load(input logic [CFG_W-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        if (w > TIMER_MAX) begin
            w = TIMER_MAX;
        end
        return w[TIMER_BITS-1:0];
    endfunction

endpackage

FILE: src/gate_access_sequencer_top.sv
// Channel   Direction  Payload
// s_axis    in         tuser: req_type; tdata: has_name, obstacle range, dwell_ms
// m_axis    out        tdata: gate_state .. passage_dwell, one word per input
// cfg       in         i_cfg_we / i_cfg_idx / i_cfg_data, seven timing registers
//
// One word per clock while m_axis does not stall: each input word is resolved by
// combinational state update and lands in the output register, which lets a new word
// in whenever it is empty or being drained in the same cycle.
// Reset (i_rst_n low, synchronous) puts the gate in idle, stops all timers
// and loads the timing registers with their defaults.
// Timers advance only on tick words; a stall on m_axis holds s_axis_tready low.
`include "assert_macros.svh"

module gate_access_sequencer_top import gas_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // has_name, obstacle range, dwell_ms, pad
    input  logic [2:0]           s_axis_tuser,  // req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // gate_state, gate_event, ack_code, servo_cmd, buzzer_cmd, display_cmd,
    // access_result, passage_valid, passage_distance, passage_dwell, pad
    output logic [55:0]          m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [19:0] r_pass_to;
    logic [13:0] r_open_tr;
    logic [13:0] r_close_tr;
    logic [15:0] r_giveup;
    logic [15:0] r_obst_ms;
    logic [9:0]  r_settle;
    logic [13:0] r_denied;

    logic [2:0]            r_state, n_state;
    logic                  r_obst, n_obst;
    logic [9:0]            r_elapsed, n_elapsed;
    t_tcnt                 r_tcnt [NUM_TIMERS];
    t_tcnt                 n_tcnt [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_trun, n_trun;
    logic [NUM_TIMERS-1:0] fired;
    logic                  do_close;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out;
    logic [OUT_W-1:0] n_out;

    logic [2:0]  ev, bz, disp;
    logic [1:0]  ack, servo, acc;
    logic        pv;
    logic [9:0]  pd;
    logic [19:0] pw;

    logic        accept;
    logic [2:0]  req;
    logic        has_name;
    logic [9:0]  obj_range;
    logic [19:0] dwell;

    assign req       = s_axis_tuser;
    assign has_name  = s_axis_tdata[0];
    assign obj_range = s_axis_tdata[10:1];
    assign dwell     = s_axis_tdata[30:11];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_to  <= RST_PASS_TO;
            r_open_tr  <= RST_OPEN_TR;
            r_close_tr <= RST_CLOSE_TR;
            r_giveup   <= RST_GIVEUP;
            r_obst_ms  <= RST_OBST;
            r_settle   <= RST_SETTLE;
            r_denied   <= RST_DENIED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PASS_TO:  r_pass_to  <= i_cfg_data;
                CFG_OPEN_TR:  r_open_tr  <= i_cfg_data[13:0];
                CFG_CLOSE_TR: r_close_tr <= i_cfg_data[13:0];
                CFG_GIVEUP:   r_giveup   <= i_cfg_data[15:0];
                CFG_OBST:     r_obst_ms  <= i_cfg_data[15:0];
                CFG_SETTLE:   r_settle   <= i_cfg_data[9:0];
                CFG_DENIED:   r_denied   <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        n_obst    = r_obst;
        n_elapsed = r_elapsed;
        n_tcnt    = r_tcnt;
        n_trun    = r_trun;
        fired     = '0;
        do_close  = 1'b0;
        ev        = EV_NONE;
        ack       = ACK_NONE;
        servo     = SERVO_NONE;
        bz        = BZ_NONE;
        disp      = DISP_NONE;
        acc       = ACC_NONE;
        pv        = 1'b0;
        pd        = '0;
        pw        = '0;

        unique case (req)
            REQ_TICK: begin
                if (r_elapsed != '1) begin
                    n_elapsed = r_elapsed + 10'd1;
                end
                // decrement all running timers before any handler looks
                for (int t = 0; t < NUM_TIMERS; t++) begin
                    if (r_trun[t]) begin
                        if (r_tcnt[t] <= t_tcnt'(1)) begin
                            fired[t]  = 1'b1;
                            n_trun[t] = 1'b0;
                            n_tcnt[t] = '0;
                        end else begin
                            n_tcnt[t] = r_tcnt[t] - t_tcnt'(1);
                        end
                    end
                end
                if (fired[T_OPEN] && n_state == ST_OPENING) begin
                    n_state         = ST_OPEN_WAIT;
                    n_elapsed       = '0;
                    ev              = EV_OPEN;
                    bz              = BZ_OK;
                    n_tcnt[T_PASS]  = tmr_load(r_pass_to);
                    n_trun[T_PASS]  = 1'b1;
                end
                if (fired[T_CLOSE] && n_state == ST_CLOSING) begin
                    n_state = ST_IDLE;
                    ev      = EV_CLOSED;
                    disp    = DISP_IDLE;
                end
                if (fired[T_OBST] && n_state == ST_OPEN_WAIT) begin
                    bz     = BZ_WARN_START;
                    n_obst = 1'b1;
                end
                if (fired[T_PASS] && n_state == ST_OPEN_WAIT) begin
                    n_state          = ST_WARN;
                    ev               = EV_WARN;
                    disp             = DISP_WARN;
                    bz               = BZ_WARN_START;
                    n_tcnt[T_GIVEUP] = tmr_load(CFG_W'(r_giveup));
                    n_trun[T_GIVEUP] = 1'b1;
                end
                if (fired[T_GIVEUP] && n_state == ST_WARN) begin
                    bz       = BZ_WARN_STOP;
                    do_close = 1'b1;
                end
                if (fired[T_DENIED] && n_state == ST_IDLE) begin
                    disp = DISP_IDLE;
                end
            end
            REQ_GRANTED: begin
                acc = ACC_GRANTED;
                if (r_state == ST_IDLE) begin
                    bz             = BZ_OK;
                    n_state        = ST_OPENING;
                    ev             = EV_OPENING;
                    disp           = has_name ? DISP_NAME : DISP_OPENING;
                    servo          = SERVO_UP;
                    n_tcnt[T_OPEN] = tmr_load(CFG_W'(r_open_tr));
                    n_trun[T_OPEN] = 1'b1;
                end else if (r_state == ST_OPEN_WAIT) begin
                    n_tcnt[T_PASS] = tmr_load(r_pass_to);
                    n_trun[T_PASS] = 1'b1;
                end
            end
            REQ_DENIED: begin
                acc              = ACC_DENIED;
                disp             = DISP_DENIED;
                bz               = BZ_ERROR;
                n_tcnt[T_DENIED] = tmr_load(CFG_W'(r_denied));
                n_trun[T_DENIED] = 1'b1;
            end
            REQ_OPEN: begin
                if (r_state == ST_IDLE) begin
                    bz             = BZ_OK;
                    n_state        = ST_OPENING;
                    ev             = EV_OPENING;
                    disp           = DISP_OPENING;
                    servo          = SERVO_UP;
                    n_tcnt[T_OPEN] = tmr_load(CFG_W'(r_open_tr));
                    n_trun[T_OPEN] = 1'b1;
                    ack            = ACK_OK;
                end else if (r_state == ST_OPEN_WAIT) begin
                    n_tcnt[T_PASS] = tmr_load(r_pass_to);
                    n_trun[T_PASS] = 1'b1;
                    ack            = ACK_OK;
                end else begin
                    ack = ACK_BUSY;
                end
            end
            REQ_CLOSE: begin
                n_trun[T_PASS]   = 1'b0;
                n_tcnt[T_PASS]   = '0;
                n_trun[T_GIVEUP] = 1'b0;
                n_tcnt[T_GIVEUP] = '0;
                n_trun[T_OBST]   = 1'b0;
                n_tcnt[T_OBST]   = '0;
                bz               = BZ_WARN_STOP;
                n_obst           = 1'b0;
                do_close         = (r_state != ST_IDLE) && (r_state != ST_CLOSING);
                ack              = ACK_OK;
            end
            REQ_PASSAGE: begin
                // drop passage while the arm settles
                if (!(r_state == ST_OPEN_WAIT && r_elapsed < r_settle)) begin
                    n_trun[T_PASS]   = 1'b0;
                    n_tcnt[T_PASS]   = '0;
                    n_trun[T_GIVEUP] = 1'b0;
                    n_tcnt[T_GIVEUP] = '0;
                    if (r_state == ST_WARN) begin
                        bz       = BZ_WARN_STOP;
                        pv       = 1'b1;
                        pd       = obj_range;
                        pw       = dwell;
                        do_close = 1'b1;
                    end else if (r_state == ST_OPEN_WAIT) begin
                        n_tcnt[T_OBST] = tmr_load(CFG_W'(r_obst_ms));
                        n_trun[T_OBST] = 1'b1;
                    end
                end
            end
            REQ_CLEARED: begin
                if (r_state == ST_OPEN_WAIT) begin
                    n_trun[T_OBST] = 1'b0;
                    n_tcnt[T_OBST] = '0;
                    if (r_obst) begin
                        bz     = BZ_WARN_STOP;
                        n_obst = 1'b0;
                    end
                    pv       = 1'b1;
                    pd       = obj_range;
                    pw       = dwell;
                    do_close = 1'b1;
                end
            end
            default: ;
        endcase

        // start closing last: it is the final writer of every field it touches
        if (do_close) begin
            n_trun[T_OBST] = 1'b0;
            n_tcnt[T_OBST] = '0;
            if (n_obst) begin
                bz = BZ_WARN_STOP;
            end
            n_obst          = 1'b0;
            n_state         = ST_CLOSING;
            ev              = EV_CLOSING;
            disp            = DISP_CLOSING;
            servo           = SERVO_DOWN;
            n_tcnt[T_CLOSE] = tmr_load(CFG_W'(r_close_tr));
            n_trun[T_CLOSE] = 1'b1;
        end

        n_out = {pw, pd, pv, acc, disp, bz, servo, ack, ev, n_state};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_obst      <= 1'b0;
            r_elapsed   <= '0;
            r_trun      <= '0;
            r_out_valid <= 1'b0;
            for (int t = 0; t < NUM_TIMERS; t++) begin
                r_tcnt[t] <= '0;
            end
        end else begin
            if (accept) begin
                r_state   <= n_state;
                r_obst    <= n_obst;
                r_elapsed <= n_elapsed;
                r_trun    <= n_trun;
                r_tcnt    <= n_tcnt;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    `GAS_ASSERT(a_obst_state, i_clk, i_rst_n, r_obst |-> (r_state == ST_OPEN_WAIT || r_state == ST_WARN))
    `GAS_ASSERT(a_opening_tmr, i_clk, i_rst_n, (r_state == ST_OPENING) |-> r_trun[T_OPEN])
    `GAS_ASSERT(a_closing_tmr, i_clk, i_rst_n, (r_state == ST_CLOSING) |-> r_trun[T_CLOSE])
    `GAS_ASSERT(a_warn_tmr, i_clk, i_rst_n, (r_state == ST_WARN) |-> r_trun[T_GIVEUP])
    `GAS_ASSERT(a_accept_out, i_clk, i_rst_n, accept |=> r_out_valid)

endmodule
